@@ rtl/core/vng_pkg.sv @@
package vng_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int PIPE_STAGES   = 9;
  localparam int OCT_STAGES    = 8;

  localparam logic [31:0] MIX_AX    = 32'd34825763;
  localparam logic [31:0] MIX_AY    = 32'd24582791;
  localparam logic [31:0] MIX_BX    = 32'd49480787;
  localparam logic [31:0] MIX_BY    = 32'd12458033;
  localparam logic [31:0] MIX_C     = 32'd38452943;
  localparam logic [31:0] MIX_XOR   = 32'd1597380049;
  localparam int          MIX_SHIFT = 13;

  localparam logic [31:0] SEED_RESET = 32'd1;

  localparam logic [31:0] RECIP_3 = 32'hAAAA_AAAB;
  localparam int          SHIFT_3 = 33;
  localparam logic [31:0] RECIP_5 = 32'hCCCC_CCCD;
  localparam int          SHIFT_5 = 34;

endpackage

@@ rtl/core/value_noise_generator_top.sv @@
// Channel   Handshake              Payload
// in        in_valid / in_ready    coord_x[31:0], coord_y[31:0]
// out       out_valid / out_ready  noise_value[15:0]
// cfg       cfg_valid / cfg_ready  noise_seed[31:0]
//
// One sample per cycle while the output is not stalled; the result passes the octave stages and an output register.
// Four octave pipelines run side by side; each stage holds at most one multiplier level.
// Reset clears all valid bits and loads the seed with one.
// A stall holds only the stages behind a full stage; bubbles are squeezed out.
module value_noise_generator_top
  import vng_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] coord_x,
  input  logic [31:0] coord_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] noise_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] noise_seed
);

  logic [31:0]          seed;
  logic [PIPE_STAGES:1] vld;
  logic [PIPE_STAGES:1] en;
  logic [FRAC_BITS-1:0] oct [4];
  logic [FRAC_BITS+1:0] sum;
  logic [FRAC_BITS-1:0] avg;
  logic [15:0]          res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      seed <= noise_seed;
    end
  end

  always_comb begin
    en[PIPE_STAGES] = !vld[PIPE_STAGES] || out_ready;
    for (int k = PIPE_STAGES - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld[PIPE_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= PIPE_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_oct
    vng_octave #(
      .FRAC_BITS(FRAC_BITS),
      .CELL     (5 - i)
    ) u_oct (
      .clk  (clk),
      .en   (en[OCT_STAGES:1]),
      .seed (seed),
      .x    (coord_x),
      .y    (coord_y),
      .value(oct[i])
    );
  end

  assign sum = (FRAC_BITS+2)'(oct[0]) + (FRAC_BITS+2)'(oct[1])
             + (FRAC_BITS+2)'(oct[2]) + (FRAC_BITS+2)'(oct[3]);
  assign avg = sum[FRAC_BITS+1:2];

  if (FRAC_BITS >= 16) begin : g_narrow
    assign res = avg[FRAC_BITS-1 -: 16];
  end else begin : g_widen
    assign res = {avg, (16-FRAC_BITS)'(0)};
  end

  always_ff @(posedge clk) begin
    if (en[PIPE_STAGES]) begin
      noise_value <= res;
    end
  end

endmodule

@@ rtl/core/vng_octave.sv @@
module vng_octave
  import vng_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int CELL      = 2
) (
  input  logic                       clk,
  input  logic [OCT_STAGES:1]        en,
  input  logic [31:0]                seed,
  input  logic [31:0]                x,
  input  logic [31:0]                y,
  output logic [FRAC_BITS-1:0]       value
);

  localparam logic [31:0] CELL_W = 32'(CELL);

  function automatic logic [FRAC_BITS-1:0] weight_of(input logic [2:0] o);
    case (o)
      3'd1:    weight_of = FRAC_BITS'(((64'd1 << FRAC_BITS) * 64'd1) / CELL);
      3'd2:    weight_of = FRAC_BITS'(((64'd1 << FRAC_BITS) * 64'd2) / CELL);
      3'd3:    weight_of = FRAC_BITS'(((64'd1 << FRAC_BITS) * 64'd3) / CELL);
      3'd4:    weight_of = FRAC_BITS'(((64'd1 << FRAC_BITS) * 64'd4) / CELL);
      default: weight_of = '0;
    endcase
  endfunction

  function automatic logic [FRAC_BITS-1:0] blend(input logic [FRAC_BITS-1:0] a,
                                                 input logic [FRAC_BITS-1:0] b,
                                                 input logic [FRAC_BITS-1:0] w);
    logic [FRAC_BITS:0]     wc;
    logic [2*FRAC_BITS+1:0] acc;
    wc  = ((FRAC_BITS+1)'(1) << FRAC_BITS) - {1'b0, w};
    acc = (2*FRAC_BITS+2)'(a) * (2*FRAC_BITS+2)'(wc)
        + (2*FRAC_BITS+2)'(b) * (2*FRAC_BITS+2)'(w);
    blend = acc[2*FRAC_BITS-1:FRAC_BITS];
  endfunction

  // stage 1
  logic [31:0] x1, y1, qx1, qy1, qx_c, qy_c;

  if ((CELL & (CELL - 1)) == 0) begin : g_pow2
    assign qx_c = x >> $clog2(CELL);
    assign qy_c = y >> $clog2(CELL);
  end else begin : g_recip
    localparam logic [31:0] RM = (CELL == 3) ? RECIP_3 : RECIP_5;
    localparam int          RS = (CELL == 3) ? SHIFT_3 : SHIFT_5;
    logic [63:0] px_full, py_full;
    assign px_full = 64'(x) * 64'(RM);
    assign py_full = 64'(y) * 64'(RM);
    assign qx_c    = 32'(px_full >> RS);
    assign qy_c    = 32'(py_full >> RS);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x1  <= x;
      y1  <= y;
      qx1 <= qx_c;
      qy1 <= qy_c;
    end
  end

  // stage 2
  logic [2:0]           ox_c, oy_c;
  logic [31:0]          px2, nx2, py2, ny2;
  logic [FRAC_BITS-1:0] wx2, wy2;

  assign ox_c = 3'(x1 - 32'(qx1 * CELL_W));
  assign oy_c = 3'(y1 - 32'(qy1 * CELL_W));

  always_ff @(posedge clk) begin
    if (en[2]) begin
      px2 <= x1 - 32'(ox_c);
      nx2 <= x1 + (CELL_W - 32'(ox_c));
      py2 <= y1 - 32'(oy_c);
      ny2 <= y1 + (CELL_W - 32'(oy_c));
      wx2 <= weight_of(ox_c);
      wy2 <= weight_of(oy_c);
    end
  end

  // stage 3
  logic [31:0]          pax3, nax3, pbx3, nbx3, pay3, nay3, pby3, nby3;
  logic [FRAC_BITS-1:0] wx3, wy3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      pax3 <= 32'(px2 * MIX_AX);
      nax3 <= 32'(nx2 * MIX_AX);
      pbx3 <= 32'(px2 * MIX_BX);
      nbx3 <= 32'(nx2 * MIX_BX);
      pay3 <= 32'(py2 * MIX_AY);
      nay3 <= 32'(ny2 * MIX_AY);
      pby3 <= 32'(py2 * MIX_BY);
      nby3 <= 32'(ny2 * MIX_BY);
      wx3  <= wx2;
      wy3  <= wy2;
    end
  end

  // stage 4: corners ld, rd, lu, ru
  logic [31:0]          sa4 [4];
  logic [31:0]          sb4 [4];
  logic [FRAC_BITS-1:0] wx4, wy4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      sa4[0] <= pax3 + pay3;
      sa4[1] <= nax3 + pay3;
      sa4[2] <= pax3 + nay3;
      sa4[3] <= nax3 + nay3;
      sb4[0] <= pbx3 + pby3;
      sb4[1] <= nbx3 + pby3;
      sb4[2] <= pbx3 + nby3;
      sb4[3] <= nbx3 + nby3;
      wx4    <= wx3;
      wy4    <= wy3;
    end
  end

  // stage 5
  logic [31:0]          p5 [4];
  logic [31:0]          q5 [4];
  logic [FRAC_BITS-1:0] wx5, wy5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int c = 0; c < 4; c++) begin
        p5[c] <= 32'(seed * sa4[c]);
        q5[c] <= 32'(seed * sb4[c]);
      end
      wx5 <= wx4;
      wy5 <= wy4;
    end
  end

  // stage 6
  logic [31:0]          h6 [4];
  logic [31:0]          m6 [4];
  logic [31:0]          hc [4];
  logic [FRAC_BITS-1:0] wx6, wy6;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      hc[c] = p5[c] ^ q5[c];
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int c = 0; c < 4; c++) begin
        h6[c] <= hc[c];
        m6[c] <= 32'((hc[c] >> MIX_SHIFT) * MIX_C);
      end
      wx6 <= wx5;
      wy6 <= wy5;
    end
  end

  // stage 7
  logic [FRAC_BITS-1:0] cv [4];
  logic [31:0]          hf [4];
  logic [FRAC_BITS-1:0] down7, up7, wy7;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      hf[c] = h6[c] ^ m6[c] ^ MIX_XOR;
      cv[c] = hf[c][31 -: FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      down7 <= blend(cv[0], cv[1], wx6);
      up7   <= blend(cv[2], cv[3], wx6);
      wy7   <= wy6;
    end
  end

  // stage 8
  always_ff @(posedge clk) begin
    if (en[8]) begin
      value <= blend(down7, up7, wy7);
    end
  end

endmodule

@@ rtl/core/vng_checker.sv @@
module vng_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] noise_value
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown straight after reset");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input refused with empty output stage");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(noise_value))
    else $error("stalled result changed");

endmodule

bind value_noise_generator_top vng_checker u_vng_checker (.*);

@@ tb/value_noise_generator_top_tb.sv @@
module value_noise_generator_top_tb
  import vng_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = FRAC_BITS_DEF;
  localparam logic [63:0] ONE_Q = 64'd1 << FB;
  localparam int DRAIN_CYCLES = 4 * PIPE_STAGES;
  localparam int NUM_DIRECTED = 14;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    bit          has_exp;
    logic [15:0] exp_val;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] coord_x = '0;
  logic [31:0] coord_y = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] noise_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] noise_seed = '0;

  logic [31:0] seed_model;
  logic [15:0] expected_samples[$];
  int          failures = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  stim_row_t   directed_rows[NUM_DIRECTED];

  value_noise_generator_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .coord_x(coord_x), .coord_y(coord_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .noise_value(noise_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .noise_seed(noise_seed)
  );

  always #4 clk = ~clk;

  initial begin
    #10ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [63:0] corner_hash(logic [31:0] x, logic [31:0] y,
                                              logic [31:0] seed);
    logic [31:0] p;
    logic [31:0] q;
    logic [31:0] h;
    p = seed * (x * MIX_AX + y * MIX_AY);
    q = seed * (x * MIX_BX + y * MIX_BY);
    h = p ^ q;
    h = h ^ ((h >> MIX_SHIFT) * MIX_C);
    h = h ^ MIX_XOR;
    return {32'd0, h} >> (32 - FB);
  endfunction

  function automatic logic [63:0] lerp_q(logic [63:0] a, logic [63:0] b,
                                         logic [63:0] w);
    return (a * (ONE_Q - w) + b * w) >> FB;
  endfunction

  function automatic logic [63:0] octave_sample(logic [31:0] x, logic [31:0] y,
                                                logic [31:0] cell_size,
                                                logic [31:0] seed);
    logic [31:0] ox;
    logic [31:0] oy;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] nx;
    logic [31:0] ny;
    logic [63:0] wx;
    logic [63:0] wy;
    ox = x % cell_size;
    oy = y % cell_size;
    px = x - ox;
    py = y - oy;
    nx = x + (cell_size - ox);
    ny = y + (cell_size - oy);
    wx = ({32'd0, ox} << FB) / cell_size;
    wy = ({32'd0, oy} << FB) / cell_size;
    return lerp_q(lerp_q(corner_hash(px, py, seed), corner_hash(nx, py, seed), wx),
                  lerp_q(corner_hash(px, ny, seed), corner_hash(nx, ny, seed), wx),
                  wy);
  endfunction

  function automatic logic [15:0] predict_noise(logic [31:0] x, logic [31:0] y);
    logic [63:0] v;
    v = (octave_sample(x, y, 5, seed_model) + octave_sample(x, y, 4, seed_model)
       + octave_sample(x, y, 3, seed_model) + octave_sample(x, y, 2, seed_model)) >> 2;
    if (FB >= 16) v = v >> (FB - 16);
    else v = v << (16 - FB);
    return v[15:0];
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected sample %h", $time, noise_value);
        failures++;
      end else begin
        if (noise_value !== expected_samples[0]) begin
          $display("%0t: noise_value expected %h actual %h", $time,
                   expected_samples[0], noise_value);
          failures++;
        end
        void'(expected_samples.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_coord(logic [31:0] x, logic [31:0] y, bit has_exp,
                            logic [15:0] exp_val);
    logic [15:0] pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    pred = predict_noise(x, y);
    if (has_exp && pred !== exp_val) begin
      $display("%0t: table row expected %h predicted %h", $time, exp_val, pred);
      failures++;
    end
    coord_x <= x;
    coord_y <= y;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_samples.push_back(pred);
    @(negedge clk);
  endtask

  task automatic drain_samples();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_samples.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_seed(logic [31:0] s);
    drain_samples();
    noise_seed <= s;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    seed_model = s;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_coord(output logic [31:0] x, output logic [31:0] y);
    case ($urandom_range(3))
      0: begin x = $urandom; y = $urandom; end
      1: begin x = $urandom_range(40); y = $urandom_range(40); end
      2: begin x = 32'hFFFF_FFFF - $urandom_range(10); y = $urandom; end
      default: begin x = $urandom; y = 32'hFFFF_FFFF - $urandom_range(10); end
    endcase
  endtask

  initial begin
    logic [31:0] rx;
    logic [31:0] ry;
    seed_model = SEED_RESET;
    directed_rows = '{
      '{32'd0, 32'd0, 1'b0, 16'd0},
      '{32'd60, 32'd60, 1'b0, 16'd0},
      '{32'd1, 32'd0, 1'b0, 16'd0},
      '{32'd0, 32'd1, 1'b0, 16'd0},
      '{32'd7, 32'd11, 1'b0, 16'd0},
      '{32'hFFFF_FFFF, 32'd0, 1'b0, 16'd0},
      '{32'd0, 32'hFFFF_FFFF, 1'b0, 16'd0},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 16'd0},
      '{32'hFFFF_FFFE, 32'hFFFF_FFFD, 1'b0, 16'd0},
      '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 16'd0},
      '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 16'd0},
      '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 16'd0},
      '{32'd59, 32'd119, 1'b0, 16'd0},
      '{32'd3, 32'd2, 1'b0, 16'd0}
    };
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_coord(directed_rows[i].x, directed_rows[i].y, directed_rows[i].has_exp,
                 directed_rows[i].exp_val);
    // zero seed: every corner hashes to the bare xor constant
    write_seed(32'd0);
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_coord(directed_rows[i].x, directed_rows[i].y, 1'b1, 16'h5F36);
    write_seed(32'hFFFF_FFFF);
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_coord(directed_rows[i].x, directed_rows[i].y, 1'b0, 16'd0);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 60 : (phase == 3) ? 28 : 0;
      recv_stall_pct = (phase == 2) ? 60 : (phase == 3) ? 28 : 0;
      write_seed((phase == 0) ? SEED_RESET : $urandom);
      for (int n = 0; n < 115; n++) begin
        if (n == 60) drain_samples();
        random_coord(rx, ry);
        send_coord(rx, ry, 1'b0, 16'd0);
      end
    end
    drain_samples();
    if (expected_samples.size() != 0) begin
      $display("%0t: %0d samples never arrived", $time, expected_samples.size());
      failures++;
    end
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
